/* design/gaussian_background_subtractor_core_assert.svh */
// assertion macros shared by the background subtractor rtl
`ifndef GAUSSIAN_BACKGROUND_SUBTRACTOR_CORE_ASSERT_SVH
`define GAUSSIAN_BACKGROUND_SUBTRACTOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gbs_pkg.sv */
// shared widths, codes and types of the background subtractor
package gbs_pkg;

    localparam int ACT_W  = 2;
    localparam int ADDR_W = 16;
    localparam int PIX_W  = 8;
    localparam int N_W    = 10;
    localparam int GAIN_W = 16;
    localparam int SUM_W  = 18;
    localparam int SQ_W   = 27;
    localparam int MEAN_W = 8;

    localparam int P1_W  = MEAN_W + SUM_W;
    localparam int MM_W  = 2 * MEAN_W;
    localparam int P2_W  = N_W + MM_W;
    localparam int DN_W  = PIX_W + N_W;
    localparam int GS_W  = GAIN_W + SQ_W;
    localparam int DEV_W = SQ_W + 2;
    localparam int PSQ_W = 2 * PIX_W;

    localparam int DIV_STAGES = 4;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TRAIN    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINALIZE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLASSIFY = 2'd3;

    localparam logic REG_TRAIN_FRAMES = 1'b0;
    localparam logic REG_THRESH_GAIN  = 1'b1;

    localparam logic [N_W-1:0]    TRAIN_FRAMES_RST = 10'd150;
    localparam logic [GAIN_W-1:0] THRESH_GAIN_RST  = 16'd256;

    localparam logic [SUM_W-1:0]  SUM_MAX = '1;
    localparam logic [SQ_W-1:0]   SQ_MAX  = '1;
    localparam logic [PIX_W-1:0]  MASK_FG = '1;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic              inr;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]   sq;
        logic [MEAN_W-1:0] mean;
    } t_stage;

    typedef struct packed {
        logic [SQ_W-1:0]   dev;
        logic [MEAN_W-1:0] mean;
        logic [PIX_W-1:0]  mask;
    } t_result;

endpackage

/* design/gbs_mean_div.sv */
// pipelined divider giving the saturated mean floor(sum / n), capped at 255
module gbs_mean_div (
    input  logic                        i_clk,
    input  logic [gbs_pkg::SUM_W-1:0]   i_sum,
    input  logic [gbs_pkg::N_W-1:0]     i_n,
    output logic [gbs_pkg::MEAN_W-1:0]  o_mean
);

    localparam int STEPS = gbs_pkg::DIV_STAGES;
    localparam int BITS  = gbs_pkg::MEAN_W / gbs_pkg::DIV_STAGES;
    localparam int SH_W  = $clog2(gbs_pkg::MEAN_W);

    logic [gbs_pkg::SUM_W-1:0]  r_rem [STEPS];
    logic [gbs_pkg::MEAN_W-1:0] r_q   [STEPS];
    logic                       r_sat [STEPS];

    generate
        for (genvar g = 0; g < STEPS; g++) begin : g_step
            logic [gbs_pkg::SUM_W-1:0]  rem_in;
            logic [gbs_pkg::SUM_W-1:0]  rem_out;
            logic [gbs_pkg::SUM_W-1:0]  trial;
            logic [gbs_pkg::MEAN_W-1:0] q_in;
            logic [gbs_pkg::MEAN_W-1:0] q_out;
            logic                       sat_in;
            logic [SH_W-1:0]            sh;

            if (g == 0) begin : g_first
                // quotient of 256 or more whenever sum >= 256 * n
                assign rem_in = i_sum;
                assign q_in   = '0;
                assign sat_in = (i_sum[gbs_pkg::SUM_W-1:gbs_pkg::MEAN_W] >= i_n);
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign q_in   = r_q[g-1];
                assign sat_in = r_sat[g-1];
            end

            always_comb begin
                rem_out = rem_in;
                q_out   = q_in;
                trial   = '0;
                sh      = '0;
                for (int b = 0; b < BITS; b++) begin
                    sh    = SH_W'(gbs_pkg::MEAN_W - 1 - g * BITS - b);
                    trial = gbs_pkg::SUM_W'(i_n) << sh;
                    if (rem_out >= trial) begin
                        rem_out   = rem_out - trial;
                        q_out[sh] = 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[g] <= rem_out;
                r_q[g]   <= q_out;
                r_sat[g] <= sat_in;
            end
        end
    endgenerate

    assign o_mean = r_sat[STEPS-1] ? '1 : r_q[STEPS-1];

endmodule

/* design/gbs_out_fifo.sv */
// result buffer between the pipeline and the output stream
module gbs_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gbs_pkg::t_result i_data,
    input  logic             i_pop,
    output gbs_pkg::t_result o_data,
    output logic             o_valid
);

    gbs_pkg::t_result             r_buf [gbs_pkg::FIFO_DEPTH];
    logic [gbs_pkg::FIFO_AW-1:0]  r_wr;
    logic [gbs_pkg::FIFO_AW-1:0]  r_rd;
    logic [gbs_pkg::FIFO_CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + gbs_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + gbs_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + gbs_pkg::FIFO_CW'(i_push) - gbs_pkg::FIFO_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];

endmodule

/* design/gaussian_background_subtractor_core.sv */
// top level: per-pixel gaussian background model held in pixel memories
//
// Requests arrive on s_axis: tuser carries the action (clear, train,
// finalize, classify), tdata the pixel address and grey level. Every
// request gives exactly one result on m_axis: foreground mask, stored mean
// and stored deviation sum of the addressed pixel after the action.
// Registers train_frames (0x0) and threshold_gain (0x4) sit on the APB
// port; write them only while no request is outstanding.
// One request is taken per cycle while fewer than 16 are outstanding; a
// request whose address matches an earlier clear, train or finalize still
// in the 8-stage read-modify-write pipeline waits until that write lands
// in the memories.
// Reset empties the pipeline and the 16-entry result buffer and loads the
// register defaults (150 frames, gain 1.0). The memories keep no reset value,
// so the user must clear each pixel before it is trained; this is not enforced.
// When m_axis stalls, results collect in the buffer and s_axis_tready
// drops once 16 requests are outstanding; nothing is dropped.
`include "gaussian_background_subtractor_core_assert.svh"

module gaussian_background_subtractor_core #(
    parameter int FRAME_PIXELS = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] pixel_addr, [23:16] pixel_value
    input  logic [gbs_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  logic [gbs_pkg::ACT_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] foreground_mask, [15:8] model_mean, [42:16] deviation_sum
    output logic [gbs_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gbs_pkg::CFG_AW-1:0]     paddr,
    input  logic [gbs_pkg::CFG_DW-1:0]     pwdata,
    output logic [gbs_pkg::CFG_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int MEM_DEPTH = (FRAME_PIXELS < 65536) ? FRAME_PIXELS : 65536;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int S_DIV     = gbs_pkg::DIV_STAGES;
    localparam int S_MUL     = S_DIV + 1;
    localparam int S_MUL2    = S_MUL + 1;
    localparam int S_WB      = S_MUL2 + 1;
    localparam int PIPE_LEN  = S_WB + 1;

    // configuration
    logic [gbs_pkg::N_W-1:0]    r_train_frames;
    logic [gbs_pkg::GAIN_W-1:0] r_thresh_gain;
    logic [gbs_pkg::N_W-1:0]    w_n;
    logic                       w_cfg_wr;

    // request side
    logic [gbs_pkg::ADDR_W-1:0] w_in_addr;
    gbs_pkg::t_stage            w_in_st;
    gbs_pkg::t_stage            w_st0;
    logic                       w_accept;
    logic                       w_pop;
    logic [PIPE_LEN-1:0]        w_wr;
    logic [PIPE_LEN-1:0]        w_hz;
    logic [gbs_pkg::FIFO_CW-1:0] r_occ;

    // pipeline
    logic [PIPE_LEN-1:0]        r_vld;
    gbs_pkg::t_stage            r_st [PIPE_LEN];

    // memories
    logic [gbs_pkg::SUM_W-1:0]  r_sum_mem  [MEM_DEPTH];
    logic [gbs_pkg::SQ_W-1:0]   r_sq_mem   [MEM_DEPTH];
    logic [gbs_pkg::MEAN_W-1:0] r_mean_mem [MEM_DEPTH];
    logic [gbs_pkg::SUM_W-1:0]  r_rd_sum;
    logic [gbs_pkg::SQ_W-1:0]   r_rd_sq;
    logic [gbs_pkg::MEAN_W-1:0] r_rd_mean;
    logic [MEM_AW-1:0]          w_rd_idx;
    logic [MEM_AW-1:0]          w_wb_idx;
    logic                       w_sum_we;
    logic                       w_sq_we;
    logic                       w_mean_we;

    // arithmetic
    logic [gbs_pkg::MEAN_W-1:0] w_div_mean;
    logic [gbs_pkg::PIX_W-1:0]  w_dif;
    logic [gbs_pkg::P1_W-1:0]   r_p1;
    logic [gbs_pkg::MM_W-1:0]   r_mm;
    logic [gbs_pkg::DN_W-1:0]   r_dn;
    logic [gbs_pkg::GS_W-1:0]   r_gs;
    logic [gbs_pkg::MEAN_W-1:0] r_mf5;
    logic [gbs_pkg::P2_W-1:0]   r_p2;
    logic [gbs_pkg::P1_W-1:0]   r_p1_6;
    logic [gbs_pkg::MEAN_W-1:0] r_mf6;
    logic                       r_fg6;
    logic [gbs_pkg::SUM_W:0]    w_sum_add;
    logic [gbs_pkg::PSQ_W-1:0]  w_pix_sq;
    logic [gbs_pkg::SQ_W:0]     w_sq_add;
    logic [gbs_pkg::DEV_W-1:0]  w_dev;
    logic [gbs_pkg::SQ_W-1:0]   w_dev_clamp;

    // writeback
    logic [gbs_pkg::SUM_W-1:0]  n_wb_sum;
    logic [gbs_pkg::SQ_W-1:0]   n_wb_sq;
    logic [gbs_pkg::MEAN_W-1:0] n_wb_mean;
    logic                       n_wb_fg;
    logic [gbs_pkg::SUM_W-1:0]  r_wb_sum;
    logic [gbs_pkg::SQ_W-1:0]   r_wb_sq;
    logic [gbs_pkg::MEAN_W-1:0] r_wb_mean;
    logic                       r_wb_fg;
    gbs_pkg::t_result           w_res;
    gbs_pkg::t_result           w_fifo_out;

    // ---------------------------------------------------------------- config
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_n      = (r_train_frames == '0) ? gbs_pkg::N_W'(1) : r_train_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_train_frames <= gbs_pkg::TRAIN_FRAMES_RST;
            r_thresh_gain  <= gbs_pkg::THRESH_GAIN_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                gbs_pkg::REG_TRAIN_FRAMES: r_train_frames <= pwdata[gbs_pkg::N_W-1:0];
                gbs_pkg::REG_THRESH_GAIN:  r_thresh_gain  <= pwdata[gbs_pkg::GAIN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            gbs_pkg::REG_TRAIN_FRAMES: prdata = gbs_pkg::CFG_DW'(r_train_frames);
            gbs_pkg::REG_THRESH_GAIN:  prdata = gbs_pkg::CFG_DW'(r_thresh_gain);
        endcase
    end

    // --------------------------------------------------------------- request
    assign w_in_addr = s_axis_tdata[gbs_pkg::ADDR_W-1:0];

    always_comb begin
        w_in_st      = '0;
        w_in_st.act  = s_axis_tuser;
        w_in_st.addr = w_in_addr;
        w_in_st.pix  = s_axis_tdata[gbs_pkg::ADDR_W +: gbs_pkg::PIX_W];
        w_in_st.inr  = (32'(w_in_addr) < 32'(FRAME_PIXELS));
    end

    // interlock against any in-flight write to the same pixel
    generate
        for (genvar k = 0; k < PIPE_LEN; k++) begin : g_hz
            assign w_wr[k] = r_vld[k] && r_st[k].inr && (r_st[k].act != gbs_pkg::ACT_CLASSIFY);
            assign w_hz[k] = w_wr[k] && (r_st[k].addr == w_in_addr);
        end
    endgenerate

    assign s_axis_tready = (r_occ < gbs_pkg::FIFO_CW'(gbs_pkg::FIFO_DEPTH)) && !(|w_hz);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    // requests in the pipeline plus results in the buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + gbs_pkg::FIFO_CW'(w_accept) - gbs_pkg::FIFO_CW'(w_pop);
        end
    end

    // -------------------------------------------------------------- pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LEN-2:0], w_accept};
        end
    end

    always_comb begin
        w_st0      = r_st[0];
        w_st0.sum  = r_rd_sum;
        w_st0.sq   = r_rd_sq;
        w_st0.mean = r_rd_mean;
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= w_in_st;
        r_st[1] <= w_st0;
    end

    generate
        for (genvar k = 2; k < PIPE_LEN; k++) begin : g_shift
            always_ff @(posedge i_clk) begin
                r_st[k] <= r_st[k-1];
            end
        end
    endgenerate

    // -------------------------------------------------------------- memories
    assign w_rd_idx  = w_in_addr[MEM_AW-1:0];
    assign w_wb_idx  = r_st[S_WB].addr[MEM_AW-1:0];
    assign w_sum_we  = w_wr[S_WB] && ((r_st[S_WB].act == gbs_pkg::ACT_CLEAR)
                                   || (r_st[S_WB].act == gbs_pkg::ACT_TRAIN));
    assign w_sq_we   = w_wr[S_WB];
    assign w_mean_we = w_wr[S_WB] && (r_st[S_WB].act == gbs_pkg::ACT_FINALIZE);

    always_ff @(posedge i_clk) begin
        if (w_sum_we) begin
            r_sum_mem[w_wb_idx] <= r_wb_sum;
        end
        r_rd_sum <= r_sum_mem[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_sq_we) begin
            r_sq_mem[w_wb_idx] <= r_wb_sq;
        end
        r_rd_sq <= r_sq_mem[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_mean_we) begin
            r_mean_mem[w_wb_idx] <= r_wb_mean;
        end
        r_rd_mean <= r_mean_mem[w_rd_idx];
    end

    // ------------------------------------------------------------ arithmetic
    gbs_mean_div u_mean_div (
        .i_clk  (i_clk),
        .i_sum  (w_st0.sum),
        .i_n    (w_n),
        .o_mean (w_div_mean)
    );

    assign w_dif = (r_st[S_DIV].pix > r_st[S_DIV].mean)
                 ? (r_st[S_DIV].pix - r_st[S_DIV].mean)
                 : (r_st[S_DIV].mean - r_st[S_DIV].pix);

    always_ff @(posedge i_clk) begin
        r_p1  <= gbs_pkg::P1_W'(w_div_mean) * gbs_pkg::P1_W'(r_st[S_DIV].sum);
        r_mm  <= gbs_pkg::MM_W'(w_div_mean) * gbs_pkg::MM_W'(w_div_mean);
        r_dn  <= gbs_pkg::DN_W'(w_dif) * gbs_pkg::DN_W'(w_n);
        r_gs  <= gbs_pkg::GS_W'(r_thresh_gain) * gbs_pkg::GS_W'(r_st[S_DIV].sq);
        r_mf5 <= w_div_mean;
    end

    // classify test: dif * n * 256 > gain * s
    always_ff @(posedge i_clk) begin
        r_p2   <= gbs_pkg::P2_W'(w_n) * gbs_pkg::P2_W'(r_mm);
        r_p1_6 <= r_p1;
        r_mf6  <= r_mf5;
        r_fg6  <= (gbs_pkg::GS_W'({r_dn, 8'h00}) > r_gs);
    end

    // deviation sum = sumsq - 2*mean*sum + n*mean^2, clamped to the field
    assign w_dev = gbs_pkg::DEV_W'(r_st[S_MUL2].sq) + gbs_pkg::DEV_W'(r_p2)
                 - gbs_pkg::DEV_W'({r_p1_6, 1'b0});

    always_comb begin
        if (w_dev[gbs_pkg::DEV_W-1]) begin
            w_dev_clamp = '0;
        end else if (w_dev[gbs_pkg::DEV_W-2:0] > (gbs_pkg::DEV_W-1)'(gbs_pkg::SQ_MAX)) begin
            w_dev_clamp = gbs_pkg::SQ_MAX;
        end else begin
            w_dev_clamp = w_dev[gbs_pkg::SQ_W-1:0];
        end
    end

    assign w_sum_add = (gbs_pkg::SUM_W+1)'(r_st[S_MUL2].sum) + (gbs_pkg::SUM_W+1)'(r_st[S_MUL2].pix);
    assign w_pix_sq  = gbs_pkg::PSQ_W'(r_st[S_MUL2].pix) * gbs_pkg::PSQ_W'(r_st[S_MUL2].pix);
    assign w_sq_add  = (gbs_pkg::SQ_W+1)'(r_st[S_MUL2].sq) + (gbs_pkg::SQ_W+1)'(w_pix_sq);

    always_comb begin
        n_wb_sum  = r_st[S_MUL2].sum;
        n_wb_sq   = r_st[S_MUL2].sq;
        n_wb_mean = r_st[S_MUL2].mean;
        n_wb_fg   = 1'b0;
        unique case (r_st[S_MUL2].act)
            gbs_pkg::ACT_CLEAR: begin
                n_wb_sum = '0;
                n_wb_sq  = '0;
            end
            gbs_pkg::ACT_TRAIN: begin
                n_wb_sum = w_sum_add[gbs_pkg::SUM_W] ? gbs_pkg::SUM_MAX
                                                     : w_sum_add[gbs_pkg::SUM_W-1:0];
                n_wb_sq  = w_sq_add[gbs_pkg::SQ_W] ? gbs_pkg::SQ_MAX
                                                   : w_sq_add[gbs_pkg::SQ_W-1:0];
            end
            gbs_pkg::ACT_FINALIZE: begin
                n_wb_sq   = w_dev_clamp;
                n_wb_mean = r_mf6;
            end
            gbs_pkg::ACT_CLASSIFY: begin
                n_wb_fg = r_fg6;
            end
        endcase
        // address beyond the frame: nothing stored, all fields zero
        if (!r_st[S_MUL2].inr) begin
            n_wb_sq   = '0;
            n_wb_mean = '0;
            n_wb_fg   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_sum  <= n_wb_sum;
        r_wb_sq   <= n_wb_sq;
        r_wb_mean <= n_wb_mean;
        r_wb_fg   <= n_wb_fg;
    end

    // ---------------------------------------------------------------- output
    always_comb begin
        w_res.mask = r_wb_fg ? gbs_pkg::MASK_FG : '0;
        w_res.mean = r_wb_mean;
        w_res.dev  = r_wb_sq;
    end

    gbs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_vld[S_WB]),
        .i_data  (w_res),
        .i_pop   (w_pop),
        .o_data  (w_fifo_out),
        .o_valid (m_axis_tvalid)
    );

    assign m_axis_tdata = gbs_pkg::M_DATA_W'(w_fifo_out);

    // ------------------------------------------------------------ assertions
    `GBS_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, 1'b1,
        r_occ <= gbs_pkg::FIFO_CW'(gbs_pkg::FIFO_DEPTH),
        "outstanding requests exceed result buffer")
    `GBS_ASSERT_NOW(a_wb_no_overlap, i_clk, i_rst_n, w_wr[S_WB] && w_wr[S_WB-1],
        r_st[S_WB].addr != r_st[S_WB-1].addr,
        "two writes to one pixel in flight together")
    `GBS_ASSERT_NOW(a_out_credit, i_clk, i_rst_n, m_axis_tvalid,
        r_occ != '0,
        "result offered with no request outstanding")
    `GBS_ASSERT_NOW(a_mask_classify, i_clk, i_rst_n,
        r_vld[S_WB] && (r_st[S_WB].act != gbs_pkg::ACT_CLASSIFY),
        w_res.mask == '0,
        "foreground mask set outside classify")
    `GBS_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, r_vld[S_WB],
        m_axis_tvalid,
        "written-back result missing from output")

endmodule
